@@ hdl/rvx_pkg.sv @@
// Shared types and constants for the RV32I execute unit.
`default_nettype none
package rvx_pkg;
  localparam int unsigned XLEN = 32;
  localparam int unsigned NREGS = 32;
  localparam logic [31:0] RESET_VECTOR_DEFAULT = 32'h0;
  localparam logic [31:0] PC_STEP = 32'd4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [4:0] OP_LUI    = 5'd0;
  localparam logic [4:0] OP_AUIPC  = 5'd1;
  localparam logic [4:0] OP_JAL    = 5'd2;
  localparam logic [4:0] OP_JALR   = 5'd3;
  localparam logic [4:0] OP_RBASE  = 5'd4;
  localparam logic [4:0] OP_IBASE  = 5'd14;
  localparam logic [4:0] OP_SB     = 5'd22;
  localparam logic [4:0] OP_SW     = 5'd24;
  localparam logic [4:0] OP_LOAD   = 5'd25;
  localparam logic [4:0] OP_BRANCH = 5'd26;

  localparam logic [3:0] ALU_ADD  = 4'd0;
  localparam logic [3:0] ALU_SUB  = 4'd1;
  localparam logic [3:0] ALU_SLL  = 4'd2;
  localparam logic [3:0] ALU_SLT  = 4'd3;
  localparam logic [3:0] ALU_SLTU = 4'd4;
  localparam logic [3:0] ALU_XOR  = 4'd5;
  localparam logic [3:0] ALU_SRL  = 4'd6;
  localparam logic [3:0] ALU_SRA  = 4'd7;
  localparam logic [3:0] ALU_OR   = 4'd8;
  localparam logic [3:0] ALU_AND  = 4'd9;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  localparam logic [2:0] F3_B  = 3'd0;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_BU = 3'd4;
  localparam logic [2:0] F3_HU = 3'd5;

  localparam logic [2:0] BR_EQ  = 3'd0;
  localparam logic [2:0] BR_NE  = 3'd1;
  localparam logic [2:0] BR_LT  = 3'd4;
  localparam logic [2:0] BR_GE  = 3'd5;
  localparam logic [2:0] BR_LTU = 3'd6;

  // Classified item passed from the front to the back
  typedef struct packed {
    logic        is_resp;
    logic        bad_code;
    logic [4:0]  op;
    logic [3:0]  alu_sel;
    logic        use_imm;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [31:0] ld;
  } rvx_item_t;

  function automatic logic [3:0] imm_alu(input logic [2:0] idx);
    logic [3:0] s;
    case (idx)
      3'd0: s = ALU_ADD;
      3'd1: s = ALU_SLT;
      3'd2: s = ALU_SLTU;
      3'd3: s = ALU_XOR;
      3'd4: s = ALU_OR;
      3'd5: s = ALU_AND;
      3'd6: s = ALU_SLL;
      default: s = ALU_SRL;
    endcase
    return s;
  endfunction
endpackage
`default_nettype wire

@@ hdl/rvx_front.sv @@
// Front end: accept items and classify the operation code.
`default_nettype none
module rvx_front (
  input  wire logic              in_action,
  input  wire logic [4:0]        in_operation,
  input  wire logic [2:0]        in_funct3,
  input  wire logic [4:0]        in_dest_reg,
  input  wire logic [4:0]        in_src1_reg,
  input  wire logic [4:0]        in_src2_reg,
  input  wire logic signed [31:0] in_immediate,
  input  wire logic [31:0]       in_load_data,
  output rvx_pkg::rvx_item_t     item
);
  import rvx_pkg::*;
  logic [4:0] ridx, iidx;

  // Decode code ranges into ALU selectors and legality
  always_comb begin
    ridx = in_operation - OP_RBASE;
    iidx = in_operation - OP_IBASE;
    item.is_resp = in_action;
    item.op      = in_operation;
    item.f3      = in_funct3;
    item.rd      = in_dest_reg;
    item.rs1     = in_src1_reg;
    item.rs2     = in_src2_reg;
    item.imm     = in_immediate;
    item.ld      = in_load_data;
    item.use_imm = (in_operation >= OP_IBASE);
    item.alu_sel = (in_operation < OP_IBASE) ? ridx[3:0] : imm_alu(iidx[2:0]);
    item.bad_code = (in_operation > OP_BRANCH)
      || (in_operation == OP_LOAD && (in_funct3 == 3'd3 || in_funct3 == 3'd6
                                      || in_funct3 == 3'd7))
      || (in_operation == OP_BRANCH && (in_funct3 == 3'd2 || in_funct3 == 3'd3));
  end
endmodule
`default_nettype wire

@@ hdl/rvx_queue.sv @@
// Short item queue between front and back.
`default_nettype none
module rvx_queue #(
  parameter int unsigned DEPTH = rvx_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_valid,
  output logic              wr_ready,
  input  rvx_pkg::rvx_item_t wr_item,
  output logic              rd_valid,
  input  wire logic         rd_ready,
  output rvx_pkg::rvx_item_t rd_item
);
  import rvx_pkg::*;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  rvx_item_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic wr_go, rd_go;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rp_r];
  assign wr_go = wr_valid && wr_ready;
  assign rd_go = rd_valid && rd_ready;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_go) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd_go) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_go) - (AW+1)'(rd_go);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) mem_r[wp_r] <= wr_item;
  end
endmodule
`default_nettype wire

@@ hdl/rvx_back.sv @@
// Back end: register file, pc, ALU, branches, loads and result register.
`default_nettype none
module rvx_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [31:0]   reset_vector,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  rvx_pkg::rvx_item_t q_item,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        out_next_pc,
  output logic [1:0]         out_mem_kind,
  output logic [31:0]        out_mem_address,
  output logic [1:0]         out_mem_width,
  output logic [31:0]        out_store_data,
  output logic               out_write_enable,
  output logic [4:0]         out_written_reg,
  output logic [31:0]        out_written_value,
  output logic               out_illegal
);
  import rvx_pkg::*;
  logic [31:0] rf_r [NREGS];
  logic [NREGS-1:0] rf_vld_r;
  logic [31:0] pc_r;
  logic pend_r;
  logic [4:0] pdst_r;
  logic [2:0] pw_r;

  logic [31:0] a, b, opb, alu_y, npc, sum, wv, ldv, sd;
  logic we, take, ill, go, is_ld, pend_nxt;
  logic [1:0] mk, mw;
  logic [4:0] wr;
  logic [1:0] sw;

  assign q_ready = !out_valid || out_ready;
  assign go = q_valid && q_ready;
  assign a = rf_vld_r[q_item.rs1] ? rf_r[q_item.rs1] : '0;
  assign b = rf_vld_r[q_item.rs2] ? rf_r[q_item.rs2] : '0;
  assign opb = q_item.use_imm ? q_item.imm : b;
  assign sum = a + q_item.imm;

  // ALU
  always_comb begin
    case (q_item.alu_sel)
      ALU_ADD:  alu_y = a + opb;
      ALU_SUB:  alu_y = a - opb;
      ALU_SLL:  alu_y = a << opb[4:0];
      ALU_SLT:  alu_y = {31'd0, $signed(a) < $signed(opb)};
      ALU_SLTU: alu_y = {31'd0, a < opb};
      ALU_XOR:  alu_y = a ^ opb;
      ALU_SRL:  alu_y = a >> opb[4:0];
      ALU_SRA:  alu_y = $unsigned($signed(a) >>> opb[4:0]);
      ALU_OR:   alu_y = a | opb;
      default:  alu_y = a & opb;
    endcase
  end

  // Branch condition
  always_comb begin
    case (q_item.f3)
      BR_EQ:  take = (a == b);
      BR_NE:  take = (a != b);
      BR_LT:  take = $signed(a) < $signed(b);
      BR_GE:  take = !($signed(a) < $signed(b));
      BR_LTU: take = a < b;
      default: take = a >= b;
    endcase
  end

  // Load data extension
  always_comb begin
    case (pw_r)
      F3_B:  ldv = {{24{q_item.ld[7]}}, q_item.ld[7:0]};
      F3_H:  ldv = {{16{q_item.ld[15]}}, q_item.ld[15:0]};
      F3_BU: ldv = {24'd0, q_item.ld[7:0]};
      F3_HU: ldv = {16'd0, q_item.ld[15:0]};
      default: ldv = q_item.ld;
    endcase
  end

  // Work out one result
  always_comb begin
    npc = pc_r + PC_STEP;
    mk = MEM_NONE; mw = 2'd0; sd = '0; ill = 1'b0;
    we = 1'b0; wr = q_item.rd; wv = '0; is_ld = 1'b0;
    pend_nxt = pend_r;
    sw = 2'(q_item.op - OP_SB);
    if (q_item.is_resp) begin
      npc = pc_r;
      if (!pend_r) ill = 1'b1;
      else begin
        we = 1'b1; wr = pdst_r; wv = ldv; pend_nxt = 1'b0;
      end
    end else if (q_item.bad_code) begin
      npc = pc_r; ill = 1'b1;
    end else begin
      pend_nxt = 1'b0;
      if (q_item.op == OP_LUI) begin
        we = 1'b1; wv = q_item.imm;
      end else if (q_item.op == OP_AUIPC) begin
        we = 1'b1; wv = pc_r + q_item.imm;
      end else if (q_item.op == OP_JAL) begin
        we = 1'b1; wv = pc_r + PC_STEP; npc = pc_r + q_item.imm;
      end else if (q_item.op == OP_JALR) begin
        we = 1'b1; wv = pc_r + PC_STEP; npc = {sum[31:1], 1'b0};
      end else if (q_item.op < OP_SB) begin
        we = 1'b1; wv = alu_y;
      end else if (q_item.op <= OP_SW) begin
        mk = MEM_WRITE; mw = sw;
        sd = (sw == 2'd0) ? {24'd0, b[7:0]} : (sw == 2'd1) ? {16'd0, b[15:0]} : b;
      end else if (q_item.op == OP_LOAD) begin
        mk = MEM_READ; mw = q_item.f3[1:0]; is_ld = 1'b1; pend_nxt = 1'b1;
      end else if (take) begin
        npc = pc_r + q_item.imm;
      end
    end
    if (wr == 5'd0) we = 1'b0;
    if (!we) begin
      wr = '0; wv = '0;
    end
  end

  // Hold architectural state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      pc_r <= reset_vector;
      pend_r <= 1'b0;
      pdst_r <= '0;
      pw_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (go) begin
        pc_r <= npc;
        pend_r <= pend_nxt;
        if (is_ld) begin
          pdst_r <= q_item.rd; pw_r <= q_item.f3;
        end
        if (we) begin
          rf_r[wr] <= wv; rf_vld_r[wr] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_next_pc <= npc;
      out_mem_kind <= mk;
      out_mem_address <= (mk != MEM_NONE) ? sum : '0;
      out_mem_width <= mw;
      out_store_data <= sd;
      out_write_enable <= we;
      out_written_reg <= wr;
      out_written_value <= wv;
      out_illegal <= ill;
    end
  end
endmodule
`default_nettype wire

@@ hdl/rv32i_execute_unit.sv @@
// Top level of the RV32I execute unit: front, item queue and back.
// An accepted item goes through the queue, then its result into the result register.
// One item per cycle, unless the queue is full or the result is held by out_ready.
// Reset: register file reads zero, no load pending, pc takes the reset_vector register,
// which itself resets to its default, so a cfg write leaves the running pc alone.
`default_nettype none
module rv32i_execute_unit #(
  parameter int unsigned QDEPTH = rvx_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [31:0]        cfg_reset_vector,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_action,
  input  wire logic [4:0]         in_operation,
  input  wire logic [2:0]         in_funct3,
  input  wire logic [4:0]         in_dest_reg,
  input  wire logic [4:0]         in_src1_reg,
  input  wire logic [4:0]         in_src2_reg,
  input  wire logic signed [31:0] in_immediate,
  input  wire logic [31:0]        in_load_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             out_next_pc,
  output logic [1:0]              out_mem_kind,
  output logic [31:0]             out_mem_address,
  output logic [1:0]              out_mem_width,
  output logic [31:0]             out_store_data,
  output logic                    out_write_enable,
  output logic [4:0]              out_written_reg,
  output logic [31:0]             out_written_value,
  output logic                    out_illegal
);
  import rvx_pkg::*;
  rvx_item_t f_item, q_item;
  logic q_valid, q_ready;
  logic [31:0] rv_r;

  assign cfg_ready = 1'b1;

  // Hold the reset vector register
  always_ff @(posedge clk) begin
    if (!rst_n) rv_r <= RESET_VECTOR_DEFAULT;
    else if (cfg_valid && cfg_ready) rv_r <= cfg_reset_vector;
  end

  rvx_front u_front (
    .in_action, .in_operation, .in_funct3, .in_dest_reg, .in_src1_reg,
    .in_src2_reg, .in_immediate, .in_load_data, .item(f_item)
  );

  rvx_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst_n, .wr_valid(in_valid), .wr_ready(in_ready), .wr_item(f_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  rvx_back u_back (
    .clk, .rst_n, .reset_vector(rv_r), .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .out_next_pc, .out_mem_kind, .out_mem_address,
    .out_mem_width, .out_store_data, .out_write_enable, .out_written_reg,
    .out_written_value, .out_illegal
  );
endmodule
`default_nettype wire
